@@ rtl/sbpm_pkg.sv @@
// Shared types and constants for the servo bus packet master.
`timescale 1ns / 1ps

package sbpm_pkg;

    // Input action codes
    typedef enum logic [2:0] {
        ACT_WR_BYTE = 3'd0,
        ACT_WR_WORD = 3'd1,
        ACT_RD_WORD = 3'd2,
        ACT_RX      = 3'd3,
        ACT_TIMEOUT = 3'd4
    } t_action;

    // Completion failure causes
    typedef enum logic [1:0] {
        CAUSE_NONE      = 2'd0,
        CAUSE_TIMEOUT   = 2'd1,
        CAUSE_BAD_HDR   = 2'd2,
        CAUSE_SERVO_ERR = 2'd3
    } t_cause;

    // Result kinds
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_DONE = 1'b1;

    // Protocol bytes
    localparam logic [7:0] HDR_BYTE   = 8'hFF;
    localparam logic [7:0] INST_READ  = 8'h02;
    localparam logic [7:0] INST_WRITE = 8'h03;
    localparam logic [7:0] LEN_SHORT  = 8'd4;
    localparam logic [7:0] LEN_WORD   = 8'd5;
    localparam logic [7:0] READ_COUNT = 8'd2;

    // Reply lengths and byte positions
    localparam logic [3:0] WRITE_REPLY_LEN = 4'd6;
    localparam logic [3:0] READ_REPLY_LEN  = 4'd8;
    localparam logic [2:0] RPOS_ID         = 3'd2;
    localparam logic [2:0] RPOS_ERR        = 3'd4;
    localparam logic [2:0] RPOS_LO         = 3'd5;
    localparam logic [2:0] RPOS_HI         = 3'd6;

    // Last frame byte index for short and word frames
    localparam logic [3:0] LAST_SHORT = 4'd7;
    localparam logic [3:0] LAST_WORD  = 4'd8;

    // Default job queue depth
    localparam int QUEUE_DEPTH = 4;

    // Job passed from the front to the back
    typedef struct packed {
        logic        is_done;
        t_action     op;
        logic [7:0]  id;
        logic [7:0]  addr;
        logic [15:0] data;
        logic [7:0]  csum;
        logic        ok;
        t_cause      cause;
        logic [7:0]  err;
    } t_job;

endpackage

@@ rtl/sbpm_fifo.sv @@
// Short job queue between the front and back of the packet master.
`timescale 1ns / 1ps

module sbpm_fifo #(
    parameter int DEPTH = sbpm_pkg::QUEUE_DEPTH
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  sbpm_pkg::t_job i_job,
    output logic          o_full,
    input  logic          i_pop,
    output sbpm_pkg::t_job o_job,
    output logic          o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    sbpm_pkg::t_job r_mem [DEPTH];
    logic [PW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_full  = (r_cnt == CNT_FULL);
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_job   = r_mem[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

@@ rtl/sbpm_front.sv @@
// Front end: accepts items, tracks the reply and queues frame and completion jobs.
`timescale 1ns / 1ps

module sbpm_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  logic [2:0]     i_action,
    input  logic [7:0]     i_servo_id,
    input  logic [7:0]     i_reg_address,
    input  logic [15:0]    i_write_value,
    input  logic [7:0]     i_rx_byte,
    input  logic           i_q_full,
    output logic           o_push,
    output sbpm_pkg::t_job o_job
);

    logic       r_awaiting, n_awaiting;
    logic       r_is_read, n_is_read;
    logic [7:0] r_exp_id, n_exp_id;
    logic [2:0] r_cnt, n_cnt;
    logic       r_hdr_ok, n_hdr_ok;
    logic [7:0] r_err, n_err;
    logic [7:0] r_lo, n_lo;
    logic [7:0] r_hi, n_hi;

    logic       accept;
    sbpm_pkg::t_action act;
    logic [7:0] len_b, inst_b, p0_b, p1_b, sum_b;
    logic [3:0] need, pos_next;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && o_in_ready;
    assign act        = sbpm_pkg::t_action'(i_action);

    // Frame fields and checksum of a command
    always_comb begin
        len_b  = (act == sbpm_pkg::ACT_WR_WORD) ? sbpm_pkg::LEN_WORD : sbpm_pkg::LEN_SHORT;
        inst_b = (act == sbpm_pkg::ACT_RD_WORD) ? sbpm_pkg::INST_READ : sbpm_pkg::INST_WRITE;
        p0_b   = (act == sbpm_pkg::ACT_RD_WORD) ? sbpm_pkg::READ_COUNT : i_write_value[7:0];
        p1_b   = (act == sbpm_pkg::ACT_WR_WORD) ? i_write_value[15:8] : 8'd0;
        sum_b  = i_servo_id + len_b + inst_b + i_reg_address + p0_b + p1_b;
    end

    assign need     = r_is_read ? sbpm_pkg::READ_REPLY_LEN : sbpm_pkg::WRITE_REPLY_LEN;
    assign pos_next = {1'b0, r_cnt} + 4'd1;

    // Classify the item, update reply tracking, build the job
    always_comb begin
        n_awaiting = r_awaiting;
        n_is_read  = r_is_read;
        n_exp_id   = r_exp_id;
        n_cnt      = r_cnt;
        n_hdr_ok   = r_hdr_ok;
        n_err      = r_err;
        n_lo       = r_lo;
        n_hi       = r_hi;
        o_push     = 1'b0;
        o_job      = '0;
        o_job.id   = i_servo_id;
        o_job.addr = i_reg_address;
        o_job.data = i_write_value;
        o_job.csum = ~sum_b;
        o_job.op   = act;
        if (accept) begin
            case (act)
                sbpm_pkg::ACT_WR_BYTE, sbpm_pkg::ACT_WR_WORD, sbpm_pkg::ACT_RD_WORD: begin
                    o_push     = 1'b1;
                    n_awaiting = 1'b1;
                    n_is_read  = (act == sbpm_pkg::ACT_RD_WORD);
                    n_exp_id   = i_servo_id;
                    n_cnt      = '0;
                    n_hdr_ok   = 1'b1;
                    n_err      = '0;
                    n_lo       = '0;
                    n_hi       = '0;
                end
                sbpm_pkg::ACT_RX: begin
                    if (r_awaiting) begin
                        // Check header and id, capture error and value bytes
                        if (r_cnt <= 3'd1 && i_rx_byte != sbpm_pkg::HDR_BYTE) begin
                            n_hdr_ok = 1'b0;
                        end
                        if (r_cnt == sbpm_pkg::RPOS_ID && i_rx_byte != r_exp_id) begin
                            n_hdr_ok = 1'b0;
                        end
                        if (r_cnt == sbpm_pkg::RPOS_ERR) begin
                            n_err = i_rx_byte;
                        end
                        if (r_cnt == sbpm_pkg::RPOS_LO) begin
                            n_lo = i_rx_byte;
                        end
                        if (r_cnt == sbpm_pkg::RPOS_HI) begin
                            n_hi = i_rx_byte;
                        end
                        n_cnt = r_cnt + 3'd1;
                        if (pos_next >= need) begin
                            n_awaiting    = 1'b0;
                            n_cnt         = '0;
                            o_push        = 1'b1;
                            o_job.is_done = 1'b1;
                            o_job.data    = '0;
                            if (!n_hdr_ok) begin
                                o_job.cause = sbpm_pkg::CAUSE_BAD_HDR;
                            end else if (n_err != 8'd0) begin
                                o_job.cause = sbpm_pkg::CAUSE_SERVO_ERR;
                                o_job.err   = n_err;
                            end else begin
                                o_job.ok    = 1'b1;
                                o_job.cause = sbpm_pkg::CAUSE_NONE;
                                o_job.data  = r_is_read ? {n_hi, n_lo} : 16'd0;
                            end
                        end
                    end
                end
                sbpm_pkg::ACT_TIMEOUT: begin
                    if (r_awaiting) begin
                        n_awaiting    = 1'b0;
                        n_cnt         = '0;
                        o_push        = 1'b1;
                        o_job.is_done = 1'b1;
                        o_job.data    = '0;
                        o_job.cause   = sbpm_pkg::CAUSE_TIMEOUT;
                    end
                end
                default: begin
                    o_push = 1'b0;
                end
            endcase
        end
    end

    // Hold reply tracking state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_awaiting <= 1'b0;
            r_is_read  <= 1'b0;
            r_exp_id   <= '0;
            r_cnt      <= '0;
            r_hdr_ok   <= 1'b0;
            r_err      <= '0;
            r_lo       <= '0;
            r_hi       <= '0;
        end else begin
            r_awaiting <= n_awaiting;
            r_is_read  <= n_is_read;
            r_exp_id   <= n_exp_id;
            r_cnt      <= n_cnt;
            r_hdr_ok   <= n_hdr_ok;
            r_err      <= n_err;
            r_lo       <= n_lo;
            r_hi       <= n_hi;
        end
    end

endmodule

@@ rtl/sbpm_back.sv @@
// Back end: expands queued jobs into frame bytes and completions on the output register.
`timescale 1ns / 1ps

module sbpm_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  sbpm_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output logic           o_result_kind,
    output logic [7:0]     o_tx_byte,
    output logic           o_last_byte,
    output logic           o_done_ok,
    output logic [1:0]     o_fail_cause,
    output logic [7:0]     o_servo_error,
    output logic [15:0]    o_read_value
);

    logic [3:0] r_idx, n_idx;
    logic       r_valid;
    logic       r_kind, r_last, r_ok;
    logic [7:0] r_tx, r_err;
    logic [1:0] r_cause;
    logic [15:0] r_val;

    logic       adv, load, job_last;
    logic [3:0] last_idx;
    logic [7:0] sel_byte;

    assign adv      = !r_valid || i_out_ready;
    assign load     = adv && !i_empty;
    assign last_idx = (i_job.op == sbpm_pkg::ACT_WR_WORD) ? sbpm_pkg::LAST_WORD
                                                          : sbpm_pkg::LAST_SHORT;
    assign job_last = i_job.is_done || (r_idx == last_idx);
    assign o_pop    = load && job_last;
    assign n_idx    = o_pop ? 4'd0 : r_idx + 4'd1;

    // Pick the frame byte at the current index
    always_comb begin
        case (r_idx)
            4'd0, 4'd1: sel_byte = sbpm_pkg::HDR_BYTE;
            4'd2:       sel_byte = i_job.id;
            4'd3:       sel_byte = (i_job.op == sbpm_pkg::ACT_WR_WORD) ? sbpm_pkg::LEN_WORD
                                                                       : sbpm_pkg::LEN_SHORT;
            4'd4:       sel_byte = (i_job.op == sbpm_pkg::ACT_RD_WORD) ? sbpm_pkg::INST_READ
                                                                       : sbpm_pkg::INST_WRITE;
            4'd5:       sel_byte = i_job.addr;
            4'd6:       sel_byte = (i_job.op == sbpm_pkg::ACT_RD_WORD) ? sbpm_pkg::READ_COUNT
                                                                       : i_job.data[7:0];
            4'd7:       sel_byte = (i_job.op == sbpm_pkg::ACT_WR_WORD) ? i_job.data[15:8]
                                                                       : i_job.csum;
            default:    sel_byte = i_job.csum;
        endcase
    end

    // Advance the byte index within a job
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_idx <= n_idx;
            end
            if (adv) begin
                r_valid <= !i_empty;
            end
        end
    end

    // Load the output register
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (i_job.is_done) begin
                r_kind  <= sbpm_pkg::KIND_DONE;
                r_tx    <= '0;
                r_last  <= 1'b0;
                r_ok    <= i_job.ok;
                r_cause <= i_job.cause;
                r_err   <= i_job.err;
                r_val   <= i_job.data;
            end else begin
                r_kind  <= sbpm_pkg::KIND_TX;
                r_tx    <= sel_byte;
                r_last  <= job_last;
                r_ok    <= 1'b0;
                r_cause <= sbpm_pkg::CAUSE_NONE;
                r_err   <= '0;
                r_val   <= '0;
            end
        end
    end

    assign o_out_valid   = r_valid;
    assign o_result_kind = r_kind;
    assign o_tx_byte     = r_tx;
    assign o_last_byte   = r_last;
    assign o_done_ok     = r_ok;
    assign o_fail_cause  = r_cause;
    assign o_servo_error = r_err;
    assign o_read_value  = r_val;

endmodule

@@ rtl/servo_bus_packet_master_core.sv @@
// Top level of the half-duplex servo bus packet master.
//
//   Channel   Dir  Handshake                 Payload
//   input     in   i_in_valid / o_in_ready   action, servo_id, reg_address, write_value, rx_byte
//   output    out  o_out_valid / i_out_ready result_kind, tx_byte, last_byte, done_ok,
//                                            fail_cause, servo_error, read_value
//
// The front takes one item per cycle while the job queue has room; reply bytes,
// timeouts and ignored items are accepted on the same terms.
// A command expands into 8 or 9 output results (one frame byte each); a
// completion into one. The back's byte index picks each frame byte in turn.
// The queue (QUEUE_DEPTH jobs) lets the front keep accepting while the output stalls.
// Reset is synchronous and active low.
`timescale 1ns / 1ps

module servo_bus_packet_master_core #(
    parameter int QUEUE_DEPTH = sbpm_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_action,
    input  logic [7:0]  i_servo_id,
    input  logic [7:0]  i_reg_address,
    input  logic [15:0] i_write_value,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_result_kind,
    output logic [7:0]  o_tx_byte,
    output logic        o_last_byte,
    output logic        o_done_ok,
    output logic [1:0]  o_fail_cause,
    output logic [7:0]  o_servo_error,
    output logic [15:0] o_read_value
);

    sbpm_pkg::t_job push_job, head_job;
    logic           push, pop, q_full, q_empty;

    // Accept and classify items
    sbpm_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_action      (i_action),
        .i_servo_id    (i_servo_id),
        .i_reg_address (i_reg_address),
        .i_write_value (i_write_value),
        .i_rx_byte     (i_rx_byte),
        .i_q_full      (q_full),
        .o_push        (push),
        .o_job         (push_job)
    );

    // Queue jobs between the two sides
    sbpm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_job   (head_job),
        .o_empty (q_empty)
    );

    // Emit frame bytes and completions
    sbpm_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job         (head_job),
        .i_empty       (q_empty),
        .o_pop         (pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_result_kind (o_result_kind),
        .o_tx_byte     (o_tx_byte),
        .o_last_byte   (o_last_byte),
        .o_done_ok     (o_done_ok),
        .o_fail_cause  (o_fail_cause),
        .o_servo_error (o_servo_error),
        .o_read_value  (o_read_value)
    );

endmodule
